// ===== sv/plf_pkg.sv =====
// ----------------------------------------------------------------------------
// plf_pkg
// Types, character codes and numeric limits shared by the plot line field
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package plf_pkg;

  // width of the internal signed coordinate arithmetic
  localparam int unsigned COORD_WIDTH = 32;
  // width of the coordinate fields in a result
  localparam int unsigned OUT_WIDTH   = 32;

  typedef logic [COORD_WIDTH-1:0] coord_t;

  // magnitude of the most negative coordinate
  localparam coord_t NEG_LIMIT = coord_t'(1) << (COORD_WIDTH - 1);
  // largest magnitude that may still take another digit (digit at or below rem)
  localparam coord_t MAG_LIMIT = NEG_LIMIT / 10;
  localparam logic [3:0] LIMIT_REM = 4'(NEG_LIMIT % 10);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;

  // item operations
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // modal D codes
  localparam logic [1:0] D_DRAW = 2'd1;
  localparam logic [1:0] D_MOVE = 2'd2;

  typedef enum logic [1:0] {
    FLD_X = 2'd0,
    FLD_Y = 2'd1,
    FLD_D = 2'd2,
    FLD_G = 2'd3
  } field_e;

  typedef enum logic [1:0] {
    ST_DROP  = 2'd0,
    ST_REC   = 2'd1,
    ST_MLINE = 2'd2
  } status_e;

  // per-field gathering flags
  typedef struct packed {
    logic started;
    logic voided;
    logic neg;
    logic digit;
    logic bad;
    logic over;
  } flags_t;

  typedef struct packed {
    logic       op;
    logic       line_start;
    logic [7:0] text_byte;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  line_status;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic        [1:0]  d_code;
    logic signed [31:0] g_code;
  } out_item_t;

  // result of one step from the parser
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/plot_line_field_parser_core.sv =====
// ----------------------------------------------------------------------------
// plot_line_field_parser_core
// Parses plotter command text byte by byte and reports, for every finished
// line, its status and the modal X, Y, D and G values after it.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    in_item_i  (op, line_start, byte)
//   out       output     out_valid_o / out_stall_i  out_item_o (status, X, Y, D, G)
//
// One item per cycle sustained while no result is held stalled; a line result
// is registered: its last byte is held in the input register, and the result
// register is loaded when the parser steps on that byte.
// The per-byte field update (one times-ten add and compare) sets the cycle.
// Reset clears line state, field flags and modal values at once.
// A stalled result holds in the result register while one more item waits in
// the input register; only then is in_stall_o raised.
// ----------------------------------------------------------------------------
`default_nettype none

module plot_line_field_parser_core
  import plf_pkg::*;
(
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      in_valid_i,
  output logic          in_stall_o,
  input  var in_item_t  in_item_i,
  output logic          out_valid_o,
  input  var logic      out_stall_i,
  output out_item_t     out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      fire;
  logic      accept;
  res_t      res;

  // step the parser when an item waits and the result slot can take one
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  plf_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .item_i (in_item_q),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept || (in_valid_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      out_item_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== sv/plf_field_conv.sv =====
// ----------------------------------------------------------------------------
// plf_field_conv
// Converts one gathered field (flags and magnitude) into a signed coordinate,
// zero on bad text, no digits or overflow, and tells whether the field is present.
// ----------------------------------------------------------------------------
`default_nettype none

module plf_field_conv
  import plf_pkg::*;
(
  input  var flags_t flags_i,
  input  var coord_t mag_i,
  output logic       present_o,
  output coord_t     value_o
);

  // a field that never got text, or began with NUL, is missing
  assign present_o = flags_i.started && !flags_i.voided;

  // signed decimal value with range check
  always_comb begin
    value_o = '0;
    if (!flags_i.bad && !flags_i.over && flags_i.digit) begin
      if (flags_i.neg) begin
        if (mag_i <= NEG_LIMIT) begin
          value_o = coord_t'(0) - mag_i;
        end
      end else begin
        if (mag_i <= NEG_LIMIT - coord_t'(1)) begin
          value_o = mag_i;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/plf_parse.sv =====
// ----------------------------------------------------------------------------
// plf_parse
// Line state, field accumulators and modal values. Works out one item per
// enabled cycle and returns the result it causes, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module plf_parse
  import plf_pkg::*;
(
  input  var logic     clk_i,
  input  var logic     rst_ni,
  input  var logic     en_i,
  input  var in_item_t item_i,
  output res_t         res_o
);

  logic   in_line_q,    in_line_d;
  logic   open_valid_q, open_valid_d;
  field_e open_fld_q,   open_fld_d;
  logic   zero_pend_q,  zero_pend_d;
  coord_t mag_q   [4];
  coord_t mag_d   [4];
  flags_t flags_q [4];
  flags_t flags_d [4];
  coord_t last_x_q, last_x_d;
  coord_t last_y_q, last_y_d;
  coord_t last_g_q, last_g_d;
  logic [1:0] last_d_q, last_d_d;

  // field view at the start of this byte (cleared on a line start)
  coord_t cur_mag   [4];
  flags_t cur_flags [4];
  logic   cur_open_valid;
  field_e cur_open_fld;
  logic   cur_zero_pend;

  logic   present [4];
  coord_t value   [4];

  // gather temporaries
  flags_t     g_flags;
  coord_t     g_mag;
  coord_t     g_lim;
  coord_t     g_mag10;
  logic       g_first;
  logic [7:0] g_diff;
  logic [3:0] g_dig;

  logic [7:0] c;
  logic       active;
  logic       emit;
  status_e    status;

  // coordinate to result width, zero extended or truncated
  function automatic logic [OUT_WIDTH-1:0] to_out(input coord_t v);
    logic [COORD_WIDTH+OUT_WIDTH-1:0] ext;
    ext = {{OUT_WIDTH{1'b0}}, v};
    return ext[OUT_WIDTH-1:0];
  endfunction

  assign c = item_i.text_byte;

  // current field view
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cur_mag[k]   = item_i.line_start ? '0 : mag_q[k];
      cur_flags[k] = item_i.line_start ? '0 : flags_q[k];
    end
    cur_open_valid = item_i.line_start ? 1'b0 : open_valid_q;
    cur_open_fld   = item_i.line_start ? FLD_X : open_fld_q;
    cur_zero_pend  = item_i.line_start ? 1'b0 : zero_pend_q;
  end

  // field converters, used when a line is recorded
  for (genvar k = 0; k < 4; k++) begin : g_conv
    plf_field_conv u_conv (
      .flags_i   (cur_flags[k]),
      .mag_i     (cur_mag[k]),
      .present_o (present[k]),
      .value_o   (value[k])
    );
  end

  // gather one byte into the open field
  always_comb begin
    g_flags = cur_flags[cur_open_fld];
    g_mag   = cur_mag[cur_open_fld];
    g_first = !g_flags.started;
    g_diff  = c - CH_ZERO;
    g_dig   = g_diff[3:0];
    g_lim   = (g_dig > LIMIT_REM) ? MAG_LIMIT - coord_t'(1) : MAG_LIMIT;
    g_mag10 = (g_mag << 3) + (g_mag << 1) + coord_t'(g_dig);
    g_flags.started = 1'b1;
    if (g_first && c == CH_NUL) begin
      g_flags.voided = 1'b1;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!g_flags.over) begin
        if (g_mag > g_lim) begin
          g_flags.over = 1'b1;
        end else begin
          g_mag = g_mag10;
        end
      end
      g_flags.digit = 1'b1;
    end else if (g_first && (c == CH_PLUS || c == CH_MINUS)) begin
      if (c == CH_MINUS) begin
        g_flags.neg = 1'b1;
      end
    end else begin
      g_flags.bad = 1'b1;
    end
  end

  // line control and modal update
  always_comb begin
    in_line_d    = in_line_q;
    open_valid_d = open_valid_q;
    open_fld_d   = open_fld_q;
    zero_pend_d  = zero_pend_q;
    mag_d        = mag_q;
    flags_d      = flags_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    last_d_d     = last_d_q;
    last_g_d     = last_g_q;
    emit         = 1'b0;
    status       = ST_DROP;
    active       = 1'b0;

    if (item_i.op == OP_CLEAR) begin
      last_x_d = '0;
      last_y_d = '0;
      last_d_d = D_MOVE;
      last_g_d = '0;
    end else begin
      if (item_i.line_start) begin
        in_line_d = 1'b1;
        active    = 1'b1;
        if (c == CH_M) begin
          in_line_d = 1'b0;
          active    = 1'b0;
          emit      = 1'b1;
          status    = ST_MLINE;
        end
      end else begin
        active = in_line_q;
      end

      if (item_i.line_start) begin
        mag_d        = cur_mag;
        flags_d      = cur_flags;
        open_valid_d = cur_open_valid;
        open_fld_d   = cur_open_fld;
        zero_pend_d  = 1'b0;
      end

      if (active) begin
        zero_pend_d = 1'b0;
        if (cur_zero_pend && c == CH_FOUR) begin
          // comment in a G field
          in_line_d = 1'b0;
          emit      = 1'b1;
          status    = ST_DROP;
        end else begin
          case (c)
            CH_X: begin
              open_valid_d = 1'b1;
              open_fld_d   = FLD_X;
            end
            CH_Y: begin
              open_valid_d = 1'b1;
              open_fld_d   = FLD_Y;
            end
            CH_D: begin
              open_valid_d = 1'b1;
              open_fld_d   = FLD_D;
            end
            CH_G: begin
              open_valid_d = 1'b1;
              open_fld_d   = FLD_G;
            end
            CH_CR, CH_LF, CH_PCT: begin
              in_line_d = 1'b0;
              emit      = 1'b1;
              status    = ST_DROP;
            end
            CH_STAR: begin
              in_line_d = 1'b0;
              emit      = 1'b1;
              status    = ST_REC;
              if (present[FLD_X]) last_x_d = value[FLD_X];
              if (present[FLD_Y]) last_y_d = value[FLD_Y];
              if (present[FLD_D]) begin
                last_d_d = (value[FLD_D] == coord_t'(1)) ? D_DRAW : D_MOVE;
              end
              if (present[FLD_G]) last_g_d = value[FLD_G];
            end
            default: begin
              if (cur_open_valid) begin
                mag_d[cur_open_fld]   = g_mag;
                flags_d[cur_open_fld] = g_flags;
                if (cur_open_fld == FLD_G && c == CH_ZERO) begin
                  zero_pend_d = 1'b1;
                end
              end
            end
          endcase
        end
      end
    end
  end

  // result of this step
  always_comb begin
    res_o.valid            = en_i && emit;
    res_o.item.line_status = status;
    res_o.item.x_coord     = to_out(last_x_d);
    res_o.item.y_coord     = to_out(last_y_d);
    res_o.item.d_code      = last_d_d;
    res_o.item.g_code      = to_out(last_g_d);
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_line_q    <= 1'b0;
      open_valid_q <= 1'b0;
      open_fld_q   <= FLD_X;
      zero_pend_q  <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        mag_q[k]   <= '0;
        flags_q[k] <= '0;
      end
      last_x_q     <= '0;
      last_y_q     <= '0;
      last_d_q     <= D_MOVE;
      last_g_q     <= '0;
    end else if (en_i) begin
      in_line_q    <= in_line_d;
      open_valid_q <= open_valid_d;
      open_fld_q   <= open_fld_d;
      zero_pend_q  <= zero_pend_d;
      mag_q        <= mag_d;
      flags_q      <= flags_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      last_d_q     <= last_d_d;
      last_g_q     <= last_g_d;
    end
  end

endmodule

`default_nettype wire
